@@ rtl/core/mrdd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrdd_pkg
// Shared constants, types and helpers for the multi-resource deadlock
// detector: sizes, opcodes, register map and controller/datapath structs.
// ----------------------------------------------------------------------------
package mrdd_pkg;

   // Sizing
   localparam int MAX_PROCESSES      = 16;
   localparam int MAX_RESOURCE_TYPES = 8;
   localparam int COUNT_BITS         = 16;

   localparam int PROC_BITS  = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
   localparam int RES_BITS   = (MAX_RESOURCE_TYPES > 1) ? $clog2(MAX_RESOURCE_TYPES) : 1;
   localparam int ADDR_BITS  = PROC_BITS + RES_BITS;
   localparam int MEM_DEPTH  = 1 << ADDR_BITS;
   // signed work value: existence minus up to MAX_PROCESSES allocations
   localparam int WORK_BITS  = COUNT_BITS + PROC_BITS + 2;

   // Fixed field widths of the stream beats
   localparam int OPC_BITS   = 2;
   localparam int PIDX_BITS  = 4;
   localparam int RIDX_BITS  = 3;
   localparam int VAL_BITS   = 16;
   localparam int PID_BITS   = 4;
   localparam int REQ_DATA_BITS = 24;
   localparam int RSP_DATA_BITS = 8;

   // Register map
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int NP_REG_BITS   = 5;
   localparam int NR_REG_BITS   = 4;
   localparam logic CSR_IDX_NP  = 1'b0;
   localparam logic CSR_IDX_NR  = 1'b1;
   localparam logic [NP_REG_BITS-1:0] NP_RESET = NP_REG_BITS'(16);
   localparam logic [NR_REG_BITS-1:0] NR_RESET = NR_REG_BITS'(8);

   typedef enum logic [OPC_BITS-1:0] {
      OPC_WR_EXIST = 2'd0,
      OPC_WR_ALLOC = 2'd1,
      OPC_WR_REQ   = 2'd2,
      OPC_RUN      = 2'd3
   } opcode_type;

   // Operation carried alongside a memory read to its data cycle
   typedef enum logic [1:0] {
      PIPE_NONE = 2'd0,
      PIPE_SUB  = 2'd1,
      PIPE_CHK  = 2'd2,
      PIPE_ADD  = 2'd3
   } pipe_op_type;

   typedef struct packed {
      logic                 load;
      logic                 init;
      pipe_op_type          rd_op;
      logic [PROC_BITS-1:0] proc;
      logic [RES_BITS-1:0]  res;
      logic                 clr_fit;
      logic                 set_fin;
      logic                 clr_prog;
      logic                 emit_load;
   } dp_cmd_type;

   typedef struct packed {
      logic                 fin_cur;
      logic                 fits;
      logic                 progress;
      logic                 rsp_free;
      logic [PROC_BITS-1:0] np_m1;
      logic [RES_BITS-1:0]  nr_m1;
   } dp_stat_type;

   // Last active process index, register saturated to 1..MAX_PROCESSES
   function automatic logic [PROC_BITS-1:0] clamp_np_m1(logic [NP_REG_BITS-1:0] v);
      logic [PROC_BITS-1:0] r;
      if (v == '0)
         r = '0;
      else if (32'(v) > MAX_PROCESSES)
         r = PROC_BITS'(MAX_PROCESSES - 1);
      else
         r = PROC_BITS'(v - NP_REG_BITS'(1));
      return r;
   endfunction

   // Last active resource index, register saturated to 1..MAX_RESOURCE_TYPES
   function automatic logic [RES_BITS-1:0] clamp_nr_m1(logic [NR_REG_BITS-1:0] v);
      logic [RES_BITS-1:0] r;
      if (v == '0)
         r = '0;
      else if (32'(v) > MAX_RESOURCE_TYPES)
         r = RES_BITS'(MAX_RESOURCE_TYPES - 1);
      else
         r = RES_BITS'(v - NR_REG_BITS'(1));
      return r;
   endfunction

endpackage

@@ rtl/core/mrdd_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrdd_ctrl
// Sequencer for the detector: accepts loads, then walks the allocation and
// request memories one element a cycle through init, passes and result beats.
// ----------------------------------------------------------------------------
module mrdd_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [1:0]                req_tuser,
   input  mrdd_pkg::dp_stat_type     stat,
   output mrdd_pkg::dp_cmd_type      cmd
);
   import mrdd_pkg::*;

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b00_0000_0001,
      ST_INIT  = 10'b00_0000_0010,
      ST_SUB   = 10'b00_0000_0100,
      ST_PASS  = 10'b00_0000_1000,
      ST_PROC  = 10'b00_0001_0000,
      ST_CHK   = 10'b00_0010_0000,
      ST_DEC   = 10'b00_0100_0000,
      ST_ADD   = 10'b00_1000_0000,
      ST_END   = 10'b01_0000_0000,
      ST_EMIT  = 10'b10_0000_0000
   } state_type;

   state_type            state_ff, state_in;
   logic [PROC_BITS-1:0] i_ff, i_in;
   logic [RES_BITS-1:0]  j_ff, j_in;
   logic                 last_i, last_j;

   assign last_i = (i_ff == stat.np_m1);
   assign last_j = (j_ff == stat.nr_m1);

   // Next state and counters
   always_comb begin
      state_in      = state_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      req_tready    = 1'b0;
      cmd           = '0;
      cmd.rd_op     = PIPE_NONE;
      cmd.proc      = i_ff;
      cmd.res       = j_ff;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (opcode_type'(req_tuser) == OPC_RUN)
                  state_in = ST_INIT;
               else
                  cmd.load = 1'b1;
            end
         end
         ST_INIT: begin
            cmd.init = 1'b1;
            i_in     = '0;
            j_in     = '0;
            state_in = ST_SUB;
         end
         ST_SUB: begin
            cmd.rd_op = PIPE_SUB;
            if (last_j) begin
               j_in = '0;
               if (last_i) begin
                  i_in     = '0;
                  state_in = ST_PASS;
               end else begin
                  i_in = i_ff + PROC_BITS'(1);
               end
            end else begin
               j_in = j_ff + RES_BITS'(1);
            end
         end
         ST_PASS: begin
            cmd.clr_prog = 1'b1;
            i_in         = '0;
            state_in     = ST_PROC;
         end
         ST_PROC: begin
            if (stat.fin_cur) begin
               if (last_i)
                  state_in = ST_END;
               else
                  i_in = i_ff + PROC_BITS'(1);
            end else begin
               cmd.clr_fit = 1'b1;
               j_in        = '0;
               state_in    = ST_CHK;
            end
         end
         ST_CHK: begin
            cmd.rd_op = PIPE_CHK;
            if (last_j) begin
               j_in     = '0;
               state_in = ST_DEC;
            end else begin
               j_in = j_ff + RES_BITS'(1);
            end
         end
         ST_DEC: begin
            if (stat.fits) begin
               cmd.set_fin = 1'b1;
               j_in        = '0;
               state_in    = ST_ADD;
            end else if (last_i) begin
               state_in = ST_END;
            end else begin
               i_in     = i_ff + PROC_BITS'(1);
               state_in = ST_PROC;
            end
         end
         ST_ADD: begin
            cmd.rd_op = PIPE_ADD;
            if (last_j) begin
               j_in = '0;
               if (last_i) begin
                  state_in = ST_END;
               end else begin
                  i_in     = i_ff + PROC_BITS'(1);
                  state_in = ST_PROC;
               end
            end else begin
               j_in = j_ff + RES_BITS'(1);
            end
         end
         ST_END: begin
            i_in = '0;
            if (stat.progress)
               state_in = ST_PASS;
            else
               state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (stat.rsp_free) begin
               cmd.emit_load = 1'b1;
               if (last_i) begin
                  i_in     = '0;
                  state_in = ST_IDLE;
               end else begin
                  i_in = i_ff + PROC_BITS'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and counter registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
      end
   end

   // The fit decision always follows a full request row walk
   a_dec_after_chk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DEC) |-> $past(state_ff == ST_CHK))
      else $error("decide state not preceded by request walk");

   // A process is never finished twice in one run
   a_set_fin_once: assert property (@(posedge clock) disable iff (reset)
      cmd.set_fin |-> !stat.fin_cur)
      else $error("finished mark set on a finished process");

   // A pass without progress leads to result beats from process zero
   a_end_to_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_END && !stat.progress) |=> (state_ff == ST_EMIT && i_ff == '0))
      else $error("run did not move to result beats");

endmodule

@@ rtl/core/mrdd_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrdd_datapath
// Register file, existence vector, allocation and request memories, work
// vector, finished marks and the result register.
// ----------------------------------------------------------------------------
module mrdd_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  mrdd_pkg::dp_cmd_type                  cmd,
   output mrdd_pkg::dp_stat_type                 stat,
   // load beat fields
   input  logic [mrdd_pkg::OPC_BITS-1:0]         ld_opcode,
   input  logic [mrdd_pkg::PIDX_BITS-1:0]        ld_proc,
   input  logic [mrdd_pkg::RIDX_BITS-1:0]        ld_res,
   input  logic [mrdd_pkg::VAL_BITS-1:0]         ld_value,
   // result register
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [mrdd_pkg::PID_BITS-1:0]         rsp_pid,
   output logic                                  rsp_dead,
   output logic                                  rsp_last,
   // register port
   input  logic                                  csr_wr,
   input  logic                                  csr_idx,
   input  logic [mrdd_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   output logic [mrdd_pkg::CSR_DATA_BITS-1:0]    csr_rdata
);
   import mrdd_pkg::*;

   logic [NP_REG_BITS-1:0]       np_reg_ff;
   logic [NR_REG_BITS-1:0]       nr_reg_ff;
   logic [COUNT_BITS-1:0]        exist_ff [MAX_RESOURCE_TYPES];
   logic [COUNT_BITS-1:0]        alloc_mem [MEM_DEPTH];
   logic [COUNT_BITS-1:0]        req_mem [MEM_DEPTH];
   logic [COUNT_BITS-1:0]        alloc_rd_ff;
   logic [COUNT_BITS-1:0]        req_rd_ff;
   logic signed [WORK_BITS-1:0]  work_ff [MAX_RESOURCE_TYPES];
   logic [MAX_PROCESSES-1:0]     fin_ff;
   logic                         fit_ff;
   logic                         prog_ff;
   pipe_op_type                  op_q_ff;
   logic [RES_BITS-1:0]          res_q_ff;
   logic                         rsp_valid_ff;
   logic [PID_BITS-1:0]          rsp_pid_ff;
   logic                         rsp_dead_ff;
   logic                         rsp_last_ff;
   logic                         in_range;
   logic [ADDR_BITS-1:0]         wr_addr;
   logic [ADDR_BITS-1:0]         rd_addr;
   logic signed [WORK_BITS-1:0]  alloc_ext;
   logic signed [WORK_BITS-1:0]  req_ext;
   logic                         req_le;
   logic [PROC_BITS-1:0]         np_m1;

   // Register file
   always_ff @(posedge clock) begin
      if (reset) begin
         np_reg_ff <= NP_RESET;
         nr_reg_ff <= NR_RESET;
      end else if (csr_wr) begin
         if (csr_idx == CSR_IDX_NP)
            np_reg_ff <= csr_wdata[NP_REG_BITS-1:0];
         else
            nr_reg_ff <= csr_wdata[NR_REG_BITS-1:0];
      end
   end

   assign csr_rdata = (csr_idx == CSR_IDX_NP) ? CSR_DATA_BITS'(np_reg_ff)
                                             : CSR_DATA_BITS'(nr_reg_ff);
   assign np_m1 = clamp_np_m1(np_reg_ff);

   // Load addressing; rows or columns beyond the array are dropped
   assign in_range = (32'(ld_proc) < MAX_PROCESSES) && (32'(ld_res) < MAX_RESOURCE_TYPES);
   assign wr_addr  = {ld_proc[PROC_BITS-1:0], ld_res[RES_BITS-1:0]};
   assign rd_addr  = {cmd.proc, cmd.res};

   // Existence vector
   always_ff @(posedge clock) begin
      if (cmd.load && opcode_type'(ld_opcode) == OPC_WR_EXIST
          && 32'(ld_res) < MAX_RESOURCE_TYPES)
         exist_ff[ld_res[RES_BITS-1:0]] <= ld_value[COUNT_BITS-1:0];
   end

   // Allocation and request memories, registered reads
   always_ff @(posedge clock) begin
      if (cmd.load && in_range && opcode_type'(ld_opcode) == OPC_WR_ALLOC)
         alloc_mem[wr_addr] <= ld_value[COUNT_BITS-1:0];
      alloc_rd_ff <= alloc_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.load && in_range && opcode_type'(ld_opcode) == OPC_WR_REQ)
         req_mem[wr_addr] <= ld_value[COUNT_BITS-1:0];
      req_rd_ff <= req_mem[rd_addr];
   end

   // Read data cycle tag
   always_ff @(posedge clock) begin
      if (reset) begin
         op_q_ff  <= PIPE_NONE;
         res_q_ff <= '0;
      end else begin
         op_q_ff  <= cmd.rd_op;
         res_q_ff <= cmd.res;
      end
   end

   assign alloc_ext = signed'({{(WORK_BITS-COUNT_BITS){1'b0}}, alloc_rd_ff});
   assign req_ext   = signed'({{(WORK_BITS-COUNT_BITS){1'b0}}, req_rd_ff});
   assign req_le    = (req_ext <= work_ff[res_q_ff]);

   // Work vector: load from existence, then subtract or add back one element
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MAX_RESOURCE_TYPES; k++)
            work_ff[k] <= '0;
      end else if (cmd.init) begin
         for (int k = 0; k < MAX_RESOURCE_TYPES; k++)
            work_ff[k] <= signed'({{(WORK_BITS-COUNT_BITS){1'b0}}, exist_ff[k]});
      end else if (op_q_ff == PIPE_SUB) begin
         work_ff[res_q_ff] <= work_ff[res_q_ff] - alloc_ext;
      end else if (op_q_ff == PIPE_ADD) begin
         work_ff[res_q_ff] <= work_ff[res_q_ff] + alloc_ext;
      end
   end

   // Row fit accumulator
   always_ff @(posedge clock) begin
      if (reset)
         fit_ff <= 1'b0;
      else if (cmd.clr_fit)
         fit_ff <= 1'b1;
      else if (op_q_ff == PIPE_CHK)
         fit_ff <= fit_ff & req_le;
   end

   // Finished marks and pass progress
   always_ff @(posedge clock) begin
      if (reset) begin
         fin_ff  <= '0;
         prog_ff <= 1'b0;
      end else begin
         if (cmd.init)
            fin_ff <= '0;
         else if (cmd.set_fin)
            fin_ff[cmd.proc] <= 1'b1;
         if (cmd.clr_prog)
            prog_ff <= 1'b0;
         else if (cmd.set_fin)
            prog_ff <= 1'b1;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (cmd.emit_load)
         rsp_valid_ff <= 1'b1;
      else if (rsp_ready)
         rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_load) begin
         rsp_pid_ff  <= PID_BITS'(cmd.proc);
         rsp_dead_ff <= !fin_ff[cmd.proc];
         rsp_last_ff <= (cmd.proc == np_m1);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pid   = rsp_pid_ff;
   assign rsp_dead  = rsp_dead_ff;
   assign rsp_last  = rsp_last_ff;

   // Status to the sequencer
   always_comb begin
      stat          = '0;
      stat.fin_cur  = fin_ff[cmd.proc];
      stat.fits     = fit_ff & ((op_q_ff != PIPE_CHK) | req_le);
      stat.progress = prog_ff;
      stat.rsp_free = !rsp_valid_ff || rsp_ready;
      stat.np_m1    = np_m1;
      stat.nr_m1    = clamp_nr_m1(nr_reg_ff);
   end

   // No load lands while a run is reading the memories
   a_no_load_in_run: assert property (@(posedge clock) disable iff (reset)
      (op_q_ff != PIPE_NONE) |-> !cmd.load)
      else $error("load during memory walk");

   // A result beat is only loaded into a free register
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result beat overwritten");

   // A run starts with no process finished
   a_init_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.init |=> (fin_ff == '0 && !cmd.set_fin))
      else $error("finished marks not cleared at run start");

endmodule

@@ rtl/core/multi_resource_deadlock_detector.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_resource_deadlock_detector
// Multiple-resource deadlock detection over a loaded existence vector,
// allocation matrix and request matrix.
// ----------------------------------------------------------------------------
// Load beats (tuser 0, 1, 2) write one element each and are taken one per
// cycle while idle. A run beat (tuser 3) holds off the input while the
// detector walks the allocation and request memories through a single read
// port, one element per cycle: it builds the work vector from existence less
// the active P by R allocations, then per pass checks the request row of each
// unfinished process and releases the allocation row of each one that fits,
// with at most P+1 passes; then P result beats, one per cycle when the sink
// is ready (P, R: active counts). The next load is accepted while the last
// result beat still waits.
// ----------------------------------------------------------------------------
module multi_resource_deadlock_detector (
   input  logic                                  clock,
   input  logic                                  reset,
   // request stream
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [mrdd_pkg::REQ_DATA_BITS-1:0]    req_tdata,  // process_index, resource_index, value, pad
   input  logic [mrdd_pkg::OPC_BITS-1:0]         req_tuser,  // opcode
   // result stream
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [mrdd_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,  // process_id, deadlocked, pad
   output logic                                  rsp_tlast,
   // register port
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [mrdd_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [mrdd_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [mrdd_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                  csr_pready
);
   import mrdd_pkg::*;

   dp_cmd_type            cmd;
   dp_stat_type           stat;
   logic                  csr_wr;
   logic [PID_BITS-1:0]   rsp_pid;
   logic                  rsp_dead;

   // Register writes complete in the access phase
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   mrdd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .stat       (stat),
      .cmd        (cmd)
   );

   mrdd_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .ld_opcode  (req_tuser),
      .ld_proc    (req_tdata[PIDX_BITS-1:0]),
      .ld_res     (req_tdata[PIDX_BITS+RIDX_BITS-1:PIDX_BITS]),
      .ld_value   (req_tdata[PIDX_BITS+RIDX_BITS+VAL_BITS-1:PIDX_BITS+RIDX_BITS]),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_pid    (rsp_pid),
      .rsp_dead   (rsp_dead),
      .rsp_last   (rsp_tlast),
      .csr_wr     (csr_wr),
      .csr_idx    (csr_paddr[2]),
      .csr_wdata  (csr_pwdata),
      .csr_rdata  (csr_prdata)
   );

   // Result beat packing
   assign rsp_tdata = {{(RSP_DATA_BITS-PID_BITS-1){1'b0}}, rsp_dead, rsp_pid};

endmodule

@@ verif/multi_resource_deadlock_detector_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_resource_deadlock_detector_tb
// Loads the existence vector and both matrices, then starts detection runs
// over a range of active process and resource counts. A scoreboard tracks
// the loaded contents and the registers, works out the deadlocked set of
// every accepted run, and checks each result beat in order. Both streams
// idle at random, and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module multi_resource_deadlock_detector_tb;
   import mrdd_pkg::*;

   localparam int STIMULUS_BEATS = 60;
   localparam int SETTLE_CYCLES  = 24;
   localparam int HOLD_CYCLES    = 400;

   typedef struct {
      logic [PID_BITS-1:0] pid;
      logic                dead;
      logic                last;
   } verdict_type;

   // Tracks memory contents and registers; predicts the verdicts of each run
   class deadlock_scoreboard;
      logic [COUNT_BITS-1:0]  existence [MAX_RESOURCE_TYPES];
      logic [COUNT_BITS-1:0]  held [MAX_PROCESSES][MAX_RESOURCE_TYPES];
      logic [COUNT_BITS-1:0]  wanted [MAX_PROCESSES][MAX_RESOURCE_TYPES];
      logic [NP_REG_BITS-1:0] np_reg = NP_RESET;
      logic [NR_REG_BITS-1:0] nr_reg = NR_RESET;
      verdict_type            verdicts [$];
      int                     errors = 0;

      function void note_config(logic idx, logic [CSR_DATA_BITS-1:0] data);
         if (idx == CSR_IDX_NP)
            np_reg = data[NP_REG_BITS-1:0];
         else
            nr_reg = data[NR_REG_BITS-1:0];
      endfunction

      // Safety check over the active part of the matrices
      function void find_deadlocks();
         int unsigned                  n_p;
         int unsigned                  n_r;
         logic signed [WORK_BITS-1:0]  avail [MAX_RESOURCE_TYPES];
         logic signed [WORK_BITS-1:0]  need;
         bit                           done [MAX_PROCESSES];
         bit                           fits;
         bit                           moved;
         verdict_type                  v;
         n_p = (np_reg == 0) ? 1 : (np_reg > MAX_PROCESSES) ? MAX_PROCESSES : np_reg;
         n_r = (nr_reg == 0) ? 1 : (nr_reg > MAX_RESOURCE_TYPES) ? MAX_RESOURCE_TYPES : nr_reg;
         for (int j = 0; j < n_r; j++) begin
            avail[j] = WORK_BITS'(existence[j]);
            for (int i = 0; i < n_p; i++)
               avail[j] = avail[j] - WORK_BITS'(held[i][j]);
         end
         foreach (done[i]) done[i] = 1'b0;
         do begin
            moved = 1'b0;
            for (int i = 0; i < n_p; i++) begin
               if (!done[i]) begin
                  fits = 1'b1;
                  for (int j = 0; j < n_r; j++) begin
                     need = WORK_BITS'(wanted[i][j]);
                     if (need > avail[j]) fits = 1'b0;
                  end
                  // release the row at once so later rows see the units
                  if (fits) begin
                     for (int j = 0; j < n_r; j++)
                        avail[j] = avail[j] + WORK_BITS'(held[i][j]);
                     done[i] = 1'b1;
                     moved = 1'b1;
                  end
               end
            end
         end while (moved);
         for (int i = 0; i < n_p; i++) begin
            v.pid  = PID_BITS'(i);
            v.dead = !done[i];
            v.last = (i == n_p - 1);
            verdicts.insert(verdicts.size(), v);
         end
      endfunction

      function void note_beat(opcode_type op, logic [PIDX_BITS-1:0] p,
                              logic [RIDX_BITS-1:0] r, logic [VAL_BITS-1:0] value);
         case (op)
            OPC_WR_EXIST: existence[r] = value;
            OPC_WR_ALLOC: held[p][r]   = value;
            OPC_WR_REQ:   wanted[p][r] = value;
            default:      find_deadlocks();
         endcase
      endfunction

      function void check_beat(logic [RSP_DATA_BITS-1:0] data, logic last);
         verdict_type v;
         if (verdicts.size() == 0) begin
            $display("%0t: result beat with nothing expected: pid %0d dead %0b last %0b",
                     $time, data[PID_BITS-1:0], data[PID_BITS], last);
            errors++;
            return;
         end
         v = verdicts.pop_front();
         if (data[PID_BITS-1:0] !== v.pid) begin
            $display("%0t: process_id expected %0d got %0d", $time, v.pid,
                     data[PID_BITS-1:0]);
            errors++;
         end
         if (data[PID_BITS] !== v.dead) begin
            $display("%0t: deadlocked for process %0d expected %0b got %0b", $time,
                     v.pid, v.dead, data[PID_BITS]);
            errors++;
         end
         if (last !== v.last) begin
            $display("%0t: last for process %0d expected %0b got %0b", $time, v.pid,
                     v.last, last);
            errors++;
         end
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [REQ_DATA_BITS-1:0]  req_tdata;   // process_index, resource_index, value, pad
   logic [OPC_BITS-1:0]       req_tuser;   // opcode
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [RSP_DATA_BITS-1:0]  rsp_tdata;   // process_id, deadlocked, pad
   logic                      rsp_tlast;
   logic                      csr_psel;
   logic                      csr_penable;
   logic                      csr_pwrite;
   logic [CSR_ADDR_BITS-1:0]  csr_paddr;
   logic [CSR_DATA_BITS-1:0]  csr_pwdata;
   logic [CSR_DATA_BITS-1:0]  csr_prdata;
   logic                      csr_pready;

   deadlock_scoreboard sb;
   int          beats_sent   = 0;
   int          results_seen = 0;
   bit          no_gaps      = 1'b0;
   int unsigned live_np      = MAX_PROCESSES;
   int unsigned live_nr      = MAX_RESOURCE_TYPES;

   multi_resource_deadlock_detector i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Run guard
   initial begin
      #10_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // Beat monitor: both channels sampled at the edge that accepts them
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            sb.check_beat(rsp_tdata, rsp_tlast);
            results_seen++;
         end
         if (req_tvalid && req_tready)
            sb.note_beat(opcode_type'(req_tuser), req_tdata[3:0], req_tdata[6:4],
                         req_tdata[22:7]);
      end
   end

   // Result sink: random stalls, ready stretches and one long hold-off
   initial begin : result_sink
      int  stall_left;
      int  ready_left;
      int  pick;
      bit  held_off;
      stall_left = 0;
      ready_left = 0;
      held_off   = 1'b0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (!held_off && results_seen >= 30 && rsp_tvalid) begin
               held_off   = 1'b1;
               stall_left = HOLD_CYCLES;
               ready_left = 0;
            end
            if (stall_left > 0) begin
               stall_left--;
               rsp_tready <= 1'b0;
            end else if (ready_left > 0) begin
               ready_left--;
               rsp_tready <= 1'b1;
            end else begin
               pick = $urandom_range(0, 99);
               if (pick < 60)
                  rsp_tready <= 1'b1;
               else if (pick < 88) begin
                  stall_left = $urandom_range(0, 2);
                  rsp_tready <= 1'b0;
               end else if (pick < 94) begin
                  stall_left = $urandom_range(20, 60);
                  rsp_tready <= 1'b0;
               end else begin
                  ready_left = $urandom_range(30, 150);
                  rsp_tready <= 1'b1;
               end
            end
         end
      end
   end

   // Sender gap after an accepted beat
   task automatic idle_gap();
      int pick;
      int gap;
      if (no_gaps) return;
      pick = $urandom_range(0, 99);
      if (pick < 60) gap = 0;
      else if (pick < 92) gap = $urandom_range(1, 3);
      else gap = $urandom_range(10, 40);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_beat(opcode_type op, int unsigned p, int unsigned r, int unsigned value);
      req_tuser  <= op;
      req_tdata  <= {1'b0, value[VAL_BITS-1:0], r[RIDX_BITS-1:0], p[PIDX_BITS-1:0]};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      beats_sent++;
      idle_gap();
   endtask

   task automatic run_detection();
      send_beat(OPC_RUN, $urandom_range(0, 15), $urandom_range(0, 7),
                $urandom_range(0, 65535));
   endtask

   // Drain: no results outstanding, then time for a trailing load to land
   task automatic settle();
      req_tvalid <= 1'b0;
      // let the monitor note a run taken at the last edge first
      @(posedge clock);
      while (sb.verdicts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write followed by a read-back
   task automatic csr_write(logic idx, logic [CSR_DATA_BITS-1:0] data);
      logic [CSR_DATA_BITS-1:0] readback;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      csr_pwrite  <= 1'b1;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      sb.note_config(idx, data);
      live_np = (sb.np_reg == 0) ? 1 :
                (sb.np_reg > MAX_PROCESSES) ? MAX_PROCESSES : sb.np_reg;
      live_nr = (sb.nr_reg == 0) ? 1 :
                (sb.nr_reg > MAX_RESOURCE_TYPES) ? MAX_RESOURCE_TYPES : sb.nr_reg;
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      readback = (idx == CSR_IDX_NP) ? CSR_DATA_BITS'(sb.np_reg) : CSR_DATA_BITS'(sb.nr_reg);
      if (csr_prdata !== readback) begin
         $display("%0t: register %0d read expected %0d got %0d", $time, idx, readback,
                  csr_prdata);
         sb.errors++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Register values: mostly small sets, sometimes the largest, sometimes out of range
   task automatic pick_config();
      int pick;
      logic [NP_REG_BITS-1:0] np_val;
      logic [NR_REG_BITS-1:0] nr_val;
      pick = $urandom_range(0, 99);
      if (pick < 70) np_val = NP_REG_BITS'($urandom_range(1, 6));
      else if (pick < 85) np_val = NP_REG_BITS'($urandom_range(7, 16));
      else if (pick < 90) np_val = '0;
      else np_val = NP_REG_BITS'($urandom_range(17, 31));
      pick = $urandom_range(0, 99);
      if (pick < 60) nr_val = NR_REG_BITS'($urandom_range(1, 4));
      else if (pick < 85) nr_val = NR_REG_BITS'($urandom_range(5, 8));
      else if (pick < 90) nr_val = '0;
      else nr_val = NR_REG_BITS'($urandom_range(9, 15));
      settle();
      csr_write(CSR_IDX_NP, {27'($urandom_range(0, 32'h07FF_FFFF)), np_val});
      csr_write(CSR_IDX_NR, {28'($urandom_range(0, 32'h0FFF_FFFF)), nr_val});
   endtask

   // Whole active region with small counts; existence mostly covers holdings
   task automatic load_region(int unsigned n_p, int unsigned n_r);
      int unsigned col_sum;
      int unsigned amount;
      for (int j = 0; j < n_r; j++) begin
         col_sum = 0;
         for (int i = 0; i < n_p; i++) begin
            amount = $urandom_range(0, 2);
            col_sum += amount;
            send_beat(OPC_WR_ALLOC, i, j, amount);
            send_beat(OPC_WR_REQ, i, j, $urandom_range(0, 3));
         end
         // now and then fewer units exist than are held: negative work
         if (col_sum > 0 && $urandom_range(0, 6) == 0)
            amount = col_sum - 1;
         else
            amount = col_sum + $urandom_range(0, 2);
         send_beat(OPC_WR_EXIST, $urandom_range(0, 15), j, amount);
      end
   endtask

   // Stimulus
   initial begin : stimulus
      int pick;
      int count;
      int unsigned value;
      sb = new;
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= OPC_WR_EXIST;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // every entry written before the first run reads any of them
      no_gaps = 1'b1;
      load_region(MAX_PROCESSES, MAX_RESOURCE_TYPES);
      no_gaps = 1'b0;

      // directed: reset sizes, extreme values, negative work, register limits
      run_detection();
      send_beat(OPC_WR_REQ, 15, 7, 16'hFFFF);
      run_detection();
      send_beat(OPC_WR_EXIST, 15, 7, 16'hFFFF);
      run_detection();
      send_beat(OPC_WR_ALLOC, 0, 0, 16'hFFFF);
      send_beat(OPC_WR_EXIST, 0, 0, 0);
      run_detection();
      settle();
      csr_write(CSR_IDX_NP, 0);
      csr_write(CSR_IDX_NR, 0);
      run_detection();
      settle();
      csr_write(CSR_IDX_NP, 32'hFFFF_FFFF);
      csr_write(CSR_IDX_NR, 32'hFFFF_FFFF);
      run_detection();
      settle();
      csr_write(CSR_IDX_NP, 1);
      csr_write(CSR_IDX_NR, 1);
      send_beat(OPC_WR_REQ, 0, 0, 0);
      run_detection();
      send_beat(OPC_WR_ALLOC, 0, 0, 1);
      send_beat(OPC_WR_EXIST, 0, 0, 1);

      // random part
      count = beats_sent + STIMULUS_BEATS;
      while (beats_sent < count) begin
         no_gaps = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 99);
         if (pick < 12)
            pick_config();
         else if (pick < 40) begin
            load_region(live_np, live_nr);
            run_detection();
         end else if (pick < 75) begin
            // a few changed entries inside the active region
            repeat ($urandom_range(1, 6)) begin
               value = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 4) :
                       ($urandom_range(0, 1) ? 16'hFFFF : $urandom_range(0, 65535));
               send_beat(opcode_type'($urandom_range(0, 2)), $urandom_range(0, live_np - 1),
                         $urandom_range(0, live_nr - 1), value);
            end
            run_detection();
         end else if (pick < 90) begin
            // loads anywhere, any value
            repeat ($urandom_range(1, 4)) begin
               value = ($urandom_range(0, 9) < 3) ? $urandom_range(0, 65535) :
                       $urandom_range(0, 4);
               send_beat(opcode_type'($urandom_range(0, 2)), $urandom_range(0, 15),
                         $urandom_range(0, 7), value);
            end
         end else
            run_detection();
      end

      settle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/mrdd_pkg.sv
rtl/core/mrdd_ctrl.sv
rtl/core/mrdd_datapath.sv
rtl/core/multi_resource_deadlock_detector.sv
verif/multi_resource_deadlock_detector_tb.sv
